// ===== hdl/nps_pkg.sv =====
// nps_pkg: shared constants, codes and types of the nearest point search block
// used by nps_point_ram, nps_dist and nearest_point_search_3d; no dependencies
package nps_pkg;

	localparam int MAX_POINTS = 64;
	localparam int IDX_W      = $clog2(MAX_POINTS);
	localparam int CNT_W      = IDX_W + 1;
	localparam int COORD_W    = 16;
	localparam int MAG_W      = 16;
	localparam int SQ_W       = 2 * MAG_W;
	localparam int DIST_W     = 34;
	localparam int MIN_W      = 7;
	localparam int IN_DATA_W  = 3 * COORD_W;
	localparam int OUT_DATA_W = 8 * ((IDX_W + DIST_W + CNT_W + 7) / 8);

	localparam logic [1:0] KIND_CLEAR  = 2'd0;
	localparam logic [1:0] KIND_APPEND = 2'd1;
	localparam logic [1:0] KIND_QUERY  = 2'd2;

	localparam logic [1:0] STATUS_DONE  = 2'd0;
	localparam logic [1:0] STATUS_FOUND = 2'd1;
	localparam logic [1:0] STATUS_FULL  = 2'd2;
	localparam logic [1:0] STATUS_FEW   = 2'd3;

	typedef struct packed {
		logic signed [COORD_W-1:0] z;
		logic signed [COORD_W-1:0] y;
		logic signed [COORD_W-1:0] x;
	} point_t;

	typedef struct packed {
		logic             valid;
		logic [IDX_W-1:0] idx;
	} tag_t;

	typedef struct packed {
		logic              valid;
		logic [IDX_W-1:0]  idx;
		logic [DIST_W-1:0] dsq;
	} dist_t;

endpackage

// ===== hdl/nps_point_ram.sv =====
// nps_point_ram: point table, one write port and one read port, registered read
// depends on nps_pkg
module nps_point_ram (
	input  logic                      clk,
	input  logic                      wr_en,
	input  logic [nps_pkg::IDX_W-1:0] wr_addr,
	input  nps_pkg::point_t           wr_data,
	input  logic [nps_pkg::IDX_W-1:0] rd_addr,
	output nps_pkg::point_t           rd_data
);

	nps_pkg::point_t mem [nps_pkg::MAX_POINTS];
	nps_pkg::point_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data_q <= mem[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

// ===== hdl/nps_dist.sv =====
// nps_dist: three-stage squared euclidean distance pipeline (abs diff, square, sum)
// depends on nps_pkg
module nps_dist (
	input  logic            clk,
	input  logic            arst_n,
	input  nps_pkg::tag_t   tag,
	input  nps_pkg::point_t pt,
	input  nps_pkg::point_t qry,
	output nps_pkg::dist_t  res
);

	function automatic logic [nps_pkg::MAG_W-1:0] abs_diff(
		input logic signed [nps_pkg::COORD_W-1:0] a,
		input logic signed [nps_pkg::COORD_W-1:0] b
	);
		logic [nps_pkg::COORD_W:0] d;
		logic [nps_pkg::COORD_W:0] m;
		d = {a[nps_pkg::COORD_W-1], a} - {b[nps_pkg::COORD_W-1], b};
		m = d[nps_pkg::COORD_W] ? (~d + 1'b1) : d;
		return m[nps_pkg::MAG_W-1:0];
	endfunction

	nps_pkg::tag_t              tag_s1, tag_s2, tag_s3;
	logic [nps_pkg::MAG_W-1:0]  mx_s1, my_s1, mz_s1;
	logic [nps_pkg::SQ_W-1:0]   sx_s2, sy_s2, sz_s2;
	logic [nps_pkg::DIST_W-1:0] sum_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1.valid <= 1'b0;
			tag_s2.valid <= 1'b0;
			tag_s3.valid <= 1'b0;
		end else begin
			tag_s1.valid <= tag.valid;
			tag_s2.valid <= tag_s1.valid;
			tag_s3.valid <= tag_s2.valid;
			tag_s1.idx   <= tag.idx;
			tag_s2.idx   <= tag_s1.idx;
			tag_s3.idx   <= tag_s2.idx;
		end
	end

	always_ff @(posedge clk) begin
		mx_s1      <= abs_diff(qry.x, pt.x);
		my_s1      <= abs_diff(qry.y, pt.y);
		mz_s1      <= abs_diff(qry.z, pt.z);
		sx_s2      <= mx_s1 * mx_s1;
		sy_s2      <= my_s1 * my_s1;
		sz_s2      <= mz_s1 * mz_s1;
		sum_s3     <= nps_pkg::DIST_W'(sx_s2) + nps_pkg::DIST_W'(sy_s2)
		            + nps_pkg::DIST_W'(sz_s2);
	end

	assign res.valid = tag_s3.valid;
	assign res.idx   = tag_s3.idx;
	assign res.dsq   = sum_s3;

endmodule

// ===== hdl/nearest_point_search_3d.sv =====
// nearest_point_search_3d: point table with clear, append and nearest point query
// depends on nps_pkg, nps_point_ram and nps_dist
//
//   channel   dir   handshake                 word
//   s_*       in    s_tvalid / s_tready       tuser kind, tdata x y z
//   m_*       out   m_tvalid / m_tready       tuser status, tdata index dist count
//   apb       in    psel penable pwrite       min_entries at address 0
//
// clear, append and unused kinds pass from idle straight to emit; a query with n
// stored points scans them one point per cycle through the single table read port
// reset empties the table count and sets min_entries to 2; table contents
// are undefined until written and are never read beyond the count
// a finished word waits in the output register while the next word is taken
module nearest_point_search_3d (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [1:0]                     s_tuser,  // kind
	input  logic [nps_pkg::IN_DATA_W-1:0]  s_tdata,  // pos_x, pos_y, pos_z
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [1:0]                     m_tuser,  // status
	output logic [nps_pkg::OUT_DATA_W-1:0] m_tdata,  // nearest_index, distance_sq, entry_count
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [2:0]                     paddr,
	input  logic [31:0]                    pwdata,
	output logic [31:0]                    prdata,
	output logic                           pready
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_EMIT = 2'd2;

	logic [1:0]                 state_q;
	logic [nps_pkg::CNT_W-1:0]  count_q;
	logic [nps_pkg::MIN_W-1:0]  min_q;
	nps_pkg::point_t            qry_q;
	logic [nps_pkg::IDX_W-1:0]  rd_idx_q;
	logic                       issue_q;
	nps_pkg::tag_t              rd_tag_q;
	logic                       have_q;
	logic [nps_pkg::DIST_W-1:0] best_d_q;
	logic [nps_pkg::IDX_W-1:0]  best_i_q;
	logic [1:0]                 res_status_q;
	logic [nps_pkg::DIST_W-1:0] res_d_q;
	logic [nps_pkg::IDX_W-1:0]  res_idx_q;
	logic                       m_tvalid_q;
	logic [1:0]                 m_tuser_q;
	logic [nps_pkg::OUT_DATA_W-1:0] m_tdata_q;

	nps_pkg::point_t            in_pt;
	nps_pkg::point_t            rd_pt;
	nps_pkg::dist_t             dres;
	logic                       in_fire;
	logic                       wr_en;
	logic                       full;
	logic                       better;
	logic                       last_dist;
	logic                       out_load;
	logic [nps_pkg::DIST_W-1:0] nxt_best_d;
	logic [nps_pkg::IDX_W-1:0]  nxt_best_i;

	// configuration
	assign pready = 1'b1;
	assign prdata = paddr[2] ? 32'd0 : 32'(min_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q <= nps_pkg::MIN_W'(2);
		end else if (psel && penable && pwrite && pready && !paddr[2]) begin
			min_q <= pwdata[nps_pkg::MIN_W-1:0];
		end
	end

	assign in_pt    = nps_pkg::point_t'(s_tdata);
	assign s_tready = (state_q == ST_IDLE);
	assign in_fire  = s_tvalid && s_tready;
	assign full     = (32'(count_q) >= nps_pkg::MAX_POINTS);
	assign wr_en    = in_fire && (s_tuser == nps_pkg::KIND_APPEND) && !full;

	nps_point_ram u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (count_q[nps_pkg::IDX_W-1:0]),
		.wr_data (in_pt),
		.rd_addr (rd_idx_q),
		.rd_data (rd_pt)
	);

	nps_dist u_dist (
		.clk    (clk),
		.arst_n (arst_n),
		.tag    (rd_tag_q),
		.pt     (rd_pt),
		.qry    (qry_q),
		.res    (dres)
	);

	assign better     = !have_q || (dres.dsq < best_d_q);
	assign nxt_best_d = better ? dres.dsq : best_d_q;
	assign nxt_best_i = better ? dres.idx : best_i_q;
	assign last_dist  = (nps_pkg::CNT_W'(dres.idx) + 1'b1 == count_q);
	assign out_load   = (state_q == ST_EMIT) && (!m_tvalid_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			count_q        <= '0;
			issue_q        <= 1'b0;
			rd_tag_q.valid <= 1'b0;
			have_q         <= 1'b0;
			m_tvalid_q     <= 1'b0;
		end else begin
			rd_tag_q.valid <= issue_q;
			rd_tag_q.idx   <= rd_idx_q;
			if (issue_q) begin
				rd_idx_q <= rd_idx_q + 1'b1;
				if (nps_pkg::CNT_W'(rd_idx_q) + 1'b1 == count_q) begin
					issue_q <= 1'b0;
				end
			end
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						state_q <= ST_EMIT;
						case (s_tuser)
							nps_pkg::KIND_CLEAR: begin
								count_q <= '0;
							end
							nps_pkg::KIND_APPEND: begin
								if (!full) begin
									count_q <= count_q + 1'b1;
								end
							end
							nps_pkg::KIND_QUERY: begin
								if (count_q != '0 && 32'(count_q) >= 32'(min_q)) begin
									state_q  <= ST_SCAN;
									issue_q  <= 1'b1;
									rd_idx_q <= '0;
									have_q   <= 1'b0;
								end
							end
							default: begin
							end
						endcase
					end
				end
				ST_SCAN: begin
					if (dres.valid) begin
						have_q <= 1'b1;
						if (last_dist) begin
							state_q <= ST_EMIT;
						end
					end
				end
				ST_EMIT: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_fire) begin
			qry_q     <= in_pt;
			res_d_q   <= '0;
			res_idx_q <= '0;
			case (s_tuser)
				nps_pkg::KIND_APPEND: res_status_q <= full ? nps_pkg::STATUS_FULL
				                                           : nps_pkg::STATUS_DONE;
				nps_pkg::KIND_QUERY:  res_status_q <= nps_pkg::STATUS_FEW;
				default:              res_status_q <= nps_pkg::STATUS_DONE;
			endcase
		end
		if (state_q == ST_SCAN && dres.valid) begin
			best_d_q <= nxt_best_d;
			best_i_q <= nxt_best_i;
			if (last_dist) begin
				res_status_q <= nps_pkg::STATUS_FOUND;
				res_d_q      <= nxt_best_d;
				res_idx_q    <= nxt_best_i;
			end
		end
		if (out_load) begin
			m_tuser_q <= res_status_q;
			m_tdata_q <= nps_pkg::OUT_DATA_W'({count_q, res_d_q, res_idx_q});
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = m_tuser_q;
	assign m_tdata  = m_tdata_q;

	// checks
	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		32'(count_q) <= nps_pkg::MAX_POINTS)
		else $error("entry count above table size");

	a_dist_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		dres.valid |-> state_q == ST_SCAN)
		else $error("distance result outside a scan");

	a_issue_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		issue_q |-> state_q == ST_SCAN && !out_load)
		else $error("table read issued outside a scan");

	a_found_index: assert property (@(posedge clk) disable iff (!arst_n)
		out_load && res_status_q == nps_pkg::STATUS_FOUND
		|-> nps_pkg::CNT_W'(res_idx_q) < count_q)
		else $error("nearest index beyond entry count");

endmodule
